>>> rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define UFR_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ufr assertion failed");

// next-cycle implication, disabled while reset is asserted
`define UFR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ufr assertion failed");

// next-cycle implication that also holds across reset
`define UFR_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("ufr assertion failed");

`endif

>>> rtl/ufr_pkg.sv
// shared types and constants of the uart frame receiver
`timescale 1ns / 1ps

package ufr_pkg;

    // frame word size, may range from 9 to 32
    localparam int MAX_WORD_BITS = 32;

    // fixed field widths
    localparam int OUT_W   = 32;
    localparam int DBM1_W  = 5;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    // derived widths
    localparam int WORD_W  = MAX_WORD_BITS;
    localparam int TOP_W   = $clog2(MAX_WORD_BITS);
    localparam int COUNT_W = $clog2(MAX_WORD_BITS + 2);

    // request codes
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PARITY_ODD    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PARITY_CHECK  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_TWO_STOP_BITS = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_BITS_M1  = CFG_IDX_W'(3);

    // reset values of the configuration registers
    localparam logic              RST_PARITY_ODD    = 1'b0;
    localparam logic              RST_PARITY_CHECK  = 1'b1;
    localparam logic              RST_TWO_STOP_BITS = 1'b1;
    localparam logic [DBM1_W-1:0] RST_DATA_BITS_M1  = DBM1_W'(7);

    typedef struct packed {
        logic req_type;
        logic line_level;
    } ufr_in_t;

    typedef struct packed {
        logic [OUT_W-1:0] rx_word;
        logic             parity_fault;
        logic             stop_fault;
    } ufr_out_t;

    typedef struct packed {
        logic              parity_odd;
        logic              parity_check;
        logic              two_stop_bits;
        logic [DBM1_W-1:0] data_bits_minus_one;
    } ufr_cfg_t;

endpackage

>>> rtl/uart_frame_receiver.sv
// top level of the uart frame receiver
//
//   channel   direction  handshake               payload
//   s_        in         s_valid / s_ready       ufr_in_t  (req_type, line_level)
//   m_        out        m_valid / m_ready       ufr_out_t (rx_word, parity/framing error)
//   cfg_      in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// one input transfer per cycle while s_ready is high; the frame state updates in the
// cycle of the transfer. a frame result is registered on its final stop bit, into the
// output register, or into the skid entry while the output register stalls. the result
// path holds two entries (output register plus skid), s_ready drops only while both are full.
// synchronous active-low reset clears frame state and loads configuration defaults.
// cfg_ready is always high; writes take effect on the next cycle.
`timescale 1ns / 1ps

module uart_frame_receiver (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  ufr_pkg::ufr_in_t               s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output ufr_pkg::ufr_out_t              m_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ufr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ufr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ufr_pkg::*;

    ufr_cfg_t cfg;
    logic     in_fire;
    logic     res_valid;
    ufr_out_t res_data;
    logic     out_fire;

    logic     main_valid_reg, main_valid_next;
    ufr_out_t main_data_reg,  main_data_next;
    logic     skid_valid_reg, skid_valid_next;
    ufr_out_t skid_data_reg,  skid_data_next;

    assign s_ready  = ~skid_valid_reg;
    assign in_fire  = s_valid & s_ready;
    assign out_fire = main_valid_reg & m_ready;
    assign m_valid  = main_valid_reg;
    assign m_data   = main_data_reg;

    ufr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ufr_frame u_frame (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .in_data   (s_data),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    // output register with skid entry
    always_comb begin
        main_valid_next = main_valid_reg;
        main_data_next  = main_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_fire) begin
            if (skid_valid_reg) begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                main_valid_next = res_valid;
                main_data_next  = res_data;
            end
        end else if (!main_valid_reg) begin
            main_valid_next = res_valid;
            main_data_next  = res_data;
        end else if (res_valid) begin
            skid_valid_next = 1'b1;
            skid_data_next  = res_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

>>> rtl/ufr_cfg_regs.sv
// configuration register file of the uart frame receiver
`timescale 1ns / 1ps

module ufr_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ufr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ufr_pkg::CFG_DATA_W-1:0] cfg_data,
    output ufr_pkg::ufr_cfg_t              cfg
);
    import ufr_pkg::*;

    ufr_cfg_t cfg_reg;
    ufr_cfg_t cfg_next;

    // writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // register decode, unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_PARITY_ODD:    cfg_next.parity_odd          = cfg_data[0];
                CFG_PARITY_CHECK:  cfg_next.parity_check        = cfg_data[0];
                CFG_TWO_STOP_BITS: cfg_next.two_stop_bits       = cfg_data[0];
                CFG_DATA_BITS_M1:  cfg_next.data_bits_minus_one = cfg_data[DBM1_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.parity_odd          <= RST_PARITY_ODD;
            cfg_reg.parity_check        <= RST_PARITY_CHECK;
            cfg_reg.two_stop_bits       <= RST_TWO_STOP_BITS;
            cfg_reg.data_bits_minus_one <= RST_DATA_BITS_M1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> rtl/ufr_frame.sv
// frame state and bit handling of the uart frame receiver
`timescale 1ns / 1ps

module ufr_frame (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_fire,
    input  ufr_pkg::ufr_in_t  in_data,
    input  ufr_pkg::ufr_cfg_t cfg,
    output logic              res_valid,
    output ufr_pkg::ufr_out_t res_data
);
    import ufr_pkg::*;

    localparam logic [DBM1_W-1:0] TOP_MAX = DBM1_W'(MAX_WORD_BITS - 1);

    logic               receiving_reg,       receiving_next;
    logic [COUNT_W-1:0] bit_count_reg,       bit_count_next;
    logic [WORD_W-1:0]  shift_word_reg,      shift_word_next;
    logic               parity_acc_reg,      parity_acc_next;
    logic               parity_seen_reg,     parity_seen_next;
    logic               extra_stop_seen_reg, extra_stop_seen_next;
    logic               parity_err_reg,      parity_err_next;
    logic               framing_err_reg,     framing_err_next;

    logic [DBM1_W-1:0]  top_sat;
    logic [TOP_W-1:0]   top;
    logic [WORD_W-1:0]  shifted_word;
    logic               sample;
    logic               in_data_phase;

    // data top bit, clamped to the word
    assign top_sat = (cfg.data_bits_minus_one > TOP_MAX) ? TOP_MAX : cfg.data_bits_minus_one;
    assign top     = top_sat[TOP_W-1:0];
    assign sample  = in_data.line_level;

    // start bit plus data bits still coming in
    assign in_data_phase = (bit_count_reg <= (COUNT_W'(top) + COUNT_W'(1)));

    // shift right and or the sample in at the top data bit
    assign shifted_word = (shift_word_reg >> 1) | (WORD_W'(sample) << top);

    // per-transfer state update
    always_comb begin
        receiving_next       = receiving_reg;
        bit_count_next       = bit_count_reg;
        shift_word_next      = shift_word_reg;
        parity_acc_next      = parity_acc_reg;
        parity_seen_next     = parity_seen_reg;
        extra_stop_seen_next = extra_stop_seen_reg;
        parity_err_next      = parity_err_reg;
        framing_err_next     = framing_err_reg;
        res_valid            = 1'b0;
        res_data.rx_word      = OUT_W'(shift_word_reg);
        res_data.parity_fault = parity_err_reg;
        res_data.stop_fault   = framing_err_reg | ~sample;

        if (in_fire) begin
            if (in_data.req_type == REQ_START) begin
                receiving_next = 1'b1;
            end else if (receiving_reg) begin
                if (in_data_phase) begin
                    bit_count_next  = bit_count_reg + COUNT_W'(1);
                    shift_word_next = shifted_word;
                    parity_acc_next = ((bit_count_reg == '0) ? cfg.parity_odd : parity_acc_reg)
                                      ^ sample;
                end else if (cfg.parity_check && !parity_seen_reg) begin
                    parity_err_next  = parity_acc_reg ^ sample;
                    parity_seen_next = 1'b1;
                end else if (cfg.two_stop_bits && !extra_stop_seen_reg) begin
                    framing_err_next     = ~sample;
                    extra_stop_seen_next = 1'b1;
                end else begin
                    // final stop bit: emit and clear the frame
                    res_valid            = 1'b1;
                    receiving_next       = 1'b0;
                    bit_count_next       = '0;
                    shift_word_next      = '0;
                    parity_acc_next      = 1'b0;
                    parity_seen_next     = 1'b0;
                    extra_stop_seen_next = 1'b0;
                    parity_err_next      = 1'b0;
                    framing_err_next     = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            receiving_reg       <= 1'b0;
            bit_count_reg       <= '0;
            shift_word_reg      <= '0;
            parity_acc_reg      <= 1'b0;
            parity_seen_reg     <= 1'b0;
            extra_stop_seen_reg <= 1'b0;
            parity_err_reg      <= 1'b0;
            framing_err_reg     <= 1'b0;
        end else begin
            receiving_reg       <= receiving_next;
            bit_count_reg       <= bit_count_next;
            shift_word_reg      <= shift_word_next;
            parity_acc_reg      <= parity_acc_next;
            parity_seen_reg     <= parity_seen_next;
            extra_stop_seen_reg <= extra_stop_seen_next;
            parity_err_reg      <= parity_err_next;
            framing_err_reg     <= framing_err_next;
        end
    end

endmodule

>>> rtl/ufr_checker.sv
// port-level assertions for the uart frame receiver
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ufr_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input ufr_pkg::ufr_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input ufr_pkg::ufr_out_t m_data
);
    import ufr_pkg::*;

    logic tick_xfer;
    logic start_xfer;

    assign tick_xfer  = s_valid && s_ready && (s_data.req_type == REQ_TICK);
    assign start_xfer = s_valid && s_ready && (s_data.req_type == REQ_START);

    // a stalled result holds
    `UFR_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // no result right after reset
    `UFR_ASSERT_NEXT_ALWAYS(a_reset_clears, aclk, !aresetn, !m_valid)

    // a new result only follows a tick transfer
    `UFR_ASSERT_IMPL(a_result_from_tick, aclk, aresetn, $rose(m_valid), $past(tick_xfer))

    // a start edge never creates a result
    `UFR_ASSERT_NEXT(a_start_no_result, aclk, aresetn, start_xfer && !m_valid, !m_valid)

    // input backpressure only while a result is pending
    `UFR_ASSERT_IMPL(a_ready_when_empty, aclk, aresetn, !s_ready, m_valid)

endmodule

bind uart_frame_receiver ufr_checker u_ufr_checker (.*);

>>> test/tb.sv
// self-checking testbench for the uart frame receiver: directed frames, random frames, stalls
`timescale 1ns / 1ps

module tb;
    import ufr_pkg::*;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = CFG_IDX_W'(15);

    localparam int IDLE_PCT      = 21;
    localparam int HOLD_CYCLES   = 300;
    localparam int ITEM_TARGET   = 950;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 8;
    localparam int NO_RESTART    = -1;
    localparam int WHOLE_FRAME   = 64;

    // frame predictor with its own copy of the registers and a store of expected frames
    class frame_scoreboard;
        ufr_cfg_t           cfg;
        bit                 armed;
        int                 bit_count;
        logic [WORD_W-1:0]  shift_word;
        bit                 parity_acc;
        bit                 parity_seen;
        bit                 extra_stop_seen;
        bit                 parity_err;
        bit                 framing_err;
        ufr_out_t           expected_frames[$];
        int                 mismatches;

        function new();
            cfg.parity_odd          = RST_PARITY_ODD;
            cfg.parity_check        = RST_PARITY_CHECK;
            cfg.two_stop_bits       = RST_TWO_STOP_BITS;
            cfg.data_bits_minus_one = RST_DATA_BITS_M1;
            mismatches = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            armed           = 1'b0;
            bit_count       = 0;
            shift_word      = '0;
            parity_acc      = 1'b0;
            parity_seen     = 1'b0;
            extra_stop_seen = 1'b0;
            parity_err      = 1'b0;
            framing_err     = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_PARITY_ODD:    cfg.parity_odd          = value[0];
                CFG_PARITY_CHECK:  cfg.parity_check        = value[0];
                CFG_TWO_STOP_BITS: cfg.two_stop_bits       = value[0];
                CFG_DATA_BITS_M1:  cfg.data_bits_minus_one = value[DBM1_W-1:0];
                default: ;
            endcase
        endfunction

        // advance the framer by one accepted transfer; returns 0 when it is dropped
        function bit accept_event(ufr_in_t ev);
            int       top;
            ufr_out_t frame;
            top = (int'(cfg.data_bits_minus_one) > MAX_WORD_BITS - 1) ? MAX_WORD_BITS - 1
                                                                      : cfg.data_bits_minus_one;
            if (ev.req_type == REQ_START) begin
                armed = 1'b1;
                return 1'b1;
            end
            if (!armed)
                return 1'b0;
            if (bit_count <= top + 1) begin
                // start bit and data bits enter at the top and shift down
                if (bit_count == 0)
                    parity_acc = cfg.parity_odd;
                bit_count++;
                shift_word = (shift_word >> 1) | (WORD_W'(ev.line_level) << top);
                parity_acc ^= ev.line_level;
            end else if (cfg.parity_check && !parity_seen) begin
                parity_err  = (parity_acc != ev.line_level);
                parity_seen = 1'b1;
            end else if (cfg.two_stop_bits && !extra_stop_seen) begin
                framing_err     = !ev.line_level;
                extra_stop_seen = 1'b1;
            end else begin
                // final stop bit closes the frame
                frame.rx_word      = OUT_W'(shift_word);
                frame.parity_fault = parity_err;
                frame.stop_fault   = framing_err | !ev.line_level;
                expected_frames.push_back(frame);
                clear_frame();
            end
            return 1'b1;
        endfunction

        function void flag(string what, ufr_out_t want, ufr_out_t got);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t %s: expected word %h perr %b ferr %b, got word %h perr %b ferr %b",
                         $realtime, what, want.rx_word, want.parity_fault, want.stop_fault,
                         got.rx_word, got.parity_fault, got.stop_fault);
        endfunction

        function void check_frame(ufr_out_t got);
            ufr_out_t want;
            if (expected_frames.size() == 0) begin
                flag("unexpected frame", '0, got);
                return;
            end
            want = expected_frames.pop_front();
            if (got.rx_word !== want.rx_word || got.parity_fault !== want.parity_fault ||
                got.stop_fault !== want.stop_fault)
                flag("frame mismatch", want, got);
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    ufr_in_t               s_data;
    logic                  m_valid;
    logic                  m_ready;
    ufr_out_t              m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    frame_scoreboard board = new();
    bit tx_calm    = 1'b0;
    bit rx_calm    = 1'b0;
    bit hold_req   = 1'b0;
    int live_items = 0;

    uart_frame_receiver u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // run limit
    initial begin
        #400000;
        $display("uart_frame_receiver test failed");
        $finish;
    end

    // result side: check each transfer, then pick the next ready level
    initial begin
        int hold_left;
        bit hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                board.check_frame(m_data);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= rx_calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // one input transfer, with occasional idle cycles ahead of it
    task automatic send_event(logic req, logic level);
        ufr_in_t ev;
        ev.req_type   = req;
        ev.line_level = level;
        while (!tx_calm && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= ev;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (board.accept_event(ev))
            live_items++;
    endtask

    // start edge plus the ticks of one frame under the current settings, maybe restarted or cut
    task automatic send_frame(logic [WORD_W-1:0] data, bit start_lvl, bit par_flip,
                              bit stop_x, bit stop_y, int restart_at, int cut);
        int top;
        bit par;
        bit ticks[$];
        top = (int'(board.cfg.data_bits_minus_one) > WORD_W - 1) ? WORD_W - 1
                                                                 : board.cfg.data_bits_minus_one;
        par = board.cfg.parity_odd ^ start_lvl;
        ticks.push_back(start_lvl);
        for (int i = 0; i <= top; i++) begin
            ticks.push_back(data[i]);
            par ^= data[i];
        end
        if (board.cfg.parity_check)
            ticks.push_back(par ^ par_flip);
        if (board.cfg.two_stop_bits)
            ticks.push_back(stop_x);
        ticks.push_back(stop_y);
        send_event(REQ_START, 1'($urandom_range(1)));
        foreach (ticks[i]) begin
            if (i >= cut)
                break;
            if (i == restart_at)
                send_event(REQ_START, 1'($urandom_range(1)));
            send_event(REQ_TICK, ticks[i]);
        end
    endtask

    function automatic logic [CFG_DATA_W-1:0] with_noise(logic [CFG_DATA_W-1:0] value,
                                                         int width);
        return (CFG_DATA_W'($urandom) << width) | value;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.write_reg(idx, value);
    endtask

    // an unmapped index, then all registers back to back, unused upper data bits randomized
    task automatic program_cfg(ufr_cfg_t c);
        write_reg(CFG_UNMAPPED, $urandom);
        write_reg(CFG_PARITY_ODD, with_noise(CFG_DATA_W'(c.parity_odd), 1));
        write_reg(CFG_PARITY_CHECK, with_noise(CFG_DATA_W'(c.parity_check), 1));
        write_reg(CFG_TWO_STOP_BITS, with_noise(CFG_DATA_W'(c.two_stop_bits), 1));
        write_reg(CFG_DATA_BITS_M1, with_noise(CFG_DATA_W'(c.data_bits_minus_one), DBM1_W));
        cfg_valid <= 1'b0;
        repeat (2) @(posedge aclk);
    endtask

    // stop offering, wait for every expected frame, then let the block settle
    task automatic wait_drained();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        while (board.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // stimulus
    initial begin
        ufr_cfg_t c;
        int       phase;
        int       nframes;
        int       pick;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // tick with the receiver idle is dropped
        send_event(REQ_TICK, 1'b1);
        // reset settings: all-ones data, bad parity, restart edge inside, low extra stop
        send_frame('1, 1'b0, 1'b1, 1'b0, 1'b1, 4, WHOLE_FRAME);
        wait_drained();

        // narrowest frame, no parity, one stop, low final stop then a clean one
        c = '{1'b1, 1'b0, 1'b0, DBM1_W'(0)};
        program_cfg(c);
        send_frame('0, 1'b0, 1'b0, 1'b1, 1'b0, NO_RESTART, WHOLE_FRAME);
        send_frame('1, 1'b0, 1'b0, 1'b1, 1'b1, NO_RESTART, WHOLE_FRAME);

        // random phases, each under its own settings; the stall phase always runs
        phase = 0;
        while (live_items < ITEM_TARGET || phase <= 5) begin
            wait_drained();
            case (phase % 8)
                0: c = '{1'b0, 1'b1, 1'b1, DBM1_W'(31)};
                1: c = '{1'b1, 1'b0, 1'b0, DBM1_W'(0)};
                2: c = '{1'b1, 1'b1, 1'b0, DBM1_W'(31)};
                5: c = '{1'b0, 1'b0, 1'b0, DBM1_W'(0)};
                default: begin
                    c.parity_odd          = 1'($urandom_range(1));
                    c.parity_check        = 1'($urandom_range(1));
                    c.two_stop_bits       = 1'($urandom_range(1));
                    c.data_bits_minus_one = DBM1_W'(($urandom_range(3) == 0)
                                                    ? $urandom_range(31)
                                                    : $urandom_range(11));
                end
            endcase
            program_cfg(c);
            tx_calm = (phase == 3 || phase == 5);
            rx_calm = (phase == 3);
            nframes = $urandom_range(4, 10);
            // long stall on the result side while short frames keep coming
            if (phase == 5) begin
                hold_req = 1'b1;
                nframes  = 30;
            end
            if (phase == 3)
                nframes = 20;
            repeat (nframes) begin
                if (phase > 5 && live_items >= ITEM_TARGET)
                    break;
                pick = $urandom_range(99);
                if (pick < 10) begin
                    // noise burst
                    repeat ($urandom_range(1, 4))
                        send_event(1'($urandom_range(1)), 1'($urandom_range(1)));
                end else if (pick < 20) begin
                    // broken frame: restart edge inside or cut short
                    send_frame($urandom, 1'($urandom_range(1)), 1'($urandom_range(1)),
                               1'($urandom_range(1)), 1'($urandom_range(1)),
                               $urandom_range(0, 10), $urandom_range(1, WHOLE_FRAME));
                end else begin
                    send_frame($urandom, $urandom_range(19) == 0, $urandom_range(6) == 0,
                               $urandom_range(6) != 0, $urandom_range(6) != 0,
                               NO_RESTART, WHOLE_FRAME);
                end
            end
            // a frame that may be cut short, so the next settings can apply mid-frame
            if ($urandom_range(2) == 0)
                send_frame($urandom, 1'b0, 1'b0, 1'b1, 1'b1, NO_RESTART,
                           $urandom_range(1, 6));
            tx_calm = 1'b0;
            rx_calm = 1'b0;
            phase++;
        end
        wait_drained();

        if (board.mismatches == 0 && board.pending() == 0)
            $display("uart_frame_receiver test passed");
        else
            $display("uart_frame_receiver test failed");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/ufr_pkg.sv
rtl/ufr_cfg_regs.sv
rtl/ufr_frame.sv
rtl/uart_frame_receiver.sv
rtl/ufr_checker.sv
test/tb.sv
